FILE: rtl/bis_pkg.sv
package bis_pkg;

   // Default table sizes
   localparam int MAX_BLOCKS_DEF = 16;
   localparam int MAX_ITEMS_DEF  = 64;

   // Field widths of the request, response and configuration ports
   localparam int OP_W       = 2;
   localparam int ADDR_W     = 6;
   localparam int KEY_W      = 32;
   localparam int START_W    = 6;
   localparam int POS_W      = 6;
   localparam int NB_W       = 5;
   localparam int LL_W       = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_WRITE_INDEX = 2'd0,
      OP_WRITE_KEY   = 2'd1,
      OP_SEARCH      = 2'd2
   } op_type;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BLOCKS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIST_LENGTH = 2'd1;
   localparam logic [NB_W-1:0]      RST_NUM_BLOCKS  = 5'd1;
   localparam logic [LL_W-1:0]      RST_LIST_LENGTH = 7'd64;

   // Microprogram step addresses
   typedef logic [2:0] step_type;
   localparam step_type STEP_INIT    = 3'd0;
   localparam step_type STEP_BS_TEST = 3'd1;
   localparam step_type STEP_BS_CMP  = 3'd2;
   localparam step_type STEP_BLK_RD  = 3'd3;
   localparam step_type STEP_BLK_SET = 3'd4;
   localparam step_type STEP_SCAN    = 3'd5;
   localparam step_type STEP_FINISH  = 3'd6;

   // Datapath action of one control word
   typedef enum logic [2:0] {
      ACT_INIT      = 3'd0,
      ACT_BS_ISSUE  = 3'd1,
      ACT_BS_UPDATE = 3'd2,
      ACT_BLK_ISSUE = 3'd3,
      ACT_BLK_SET   = 3'd4,
      ACT_SCAN      = 3'd5,
      ACT_FINISH    = 3'd6
   } act_type;

   // Jump condition of one control word
   typedef enum logic [2:0] {
      COND_NEVER     = 3'd0,
      COND_ALWAYS    = 3'd1,
      COND_LO_GE_HI  = 3'd2,
      COND_BLK_NONE  = 3'd3,
      COND_SCAN_MORE = 3'd4
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } uword_type;

   // Sequencer to datapath
   typedef struct packed {
      logic    fire;
      act_type act;
   } ctl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic lo_ge_hi;
      logic blk_none;
      logic scan_more;
   } stat_type;

   // Load and start strobes from the request port
   typedef struct packed {
      logic                     idx_we;
      logic                     key_we;
      logic                     start;
      logic [ADDR_W-1:0]        addr;
      logic signed [KEY_W-1:0]  key;
      logic [START_W-1:0]       blk_start;
   } load_type;

   // Search microprogram: jump to target when the condition holds, else fall through
   function automatic uword_type ucode_word(input step_type step);
      uword_type w;
      case (step)
         STEP_INIT:    w = '{ACT_INIT,      COND_NEVER,     STEP_INIT};
         STEP_BS_TEST: w = '{ACT_BS_ISSUE,  COND_LO_GE_HI,  STEP_BLK_RD};
         STEP_BS_CMP:  w = '{ACT_BS_UPDATE, COND_ALWAYS,    STEP_BS_TEST};
         STEP_BLK_RD:  w = '{ACT_BLK_ISSUE, COND_BLK_NONE,  STEP_FINISH};
         STEP_BLK_SET: w = '{ACT_BLK_SET,   COND_NEVER,     STEP_INIT};
         STEP_SCAN:    w = '{ACT_SCAN,      COND_SCAN_MORE, STEP_SCAN};
         STEP_FINISH:  w = '{ACT_FINISH,    COND_NEVER,     STEP_INIT};
         default:      w = '{ACT_FINISH,    COND_NEVER,     STEP_INIT};
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/block_index_search_core.sv
// Channel    Handshake              Payload
// req        req_valid/req_ready    req_operation, req_address, req_key_value, req_block_start
// rsp        rsp_valid/rsp_ready    rsp_found, rsp_position
// csr        csr_valid/csr_ready    csr_index, csr_wdata
//
// Loads give no response. A search runs a microprogram: a binary search
// over m index entries, a fetch of the block bounds, a scan of the block's
// list keys from its end downward, and a final step that posts the
// response.
// Reset is synchronous; the tables hold no reset value and need no clearing.
// A held response stalls only the final step; requests wait while a search runs.
module block_index_search_core #(
   parameter int MAX_BLOCKS = bis_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_ITEMS  = bis_pkg::MAX_ITEMS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bis_pkg::OP_W-1:0]         req_operation,
   input  logic [bis_pkg::ADDR_W-1:0]       req_address,
   input  logic signed [bis_pkg::KEY_W-1:0] req_key_value,
   input  logic [bis_pkg::START_W-1:0]      req_block_start,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [bis_pkg::POS_W-1:0]        rsp_position,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bis_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bis_pkg::*;

   logic [NB_W-1:0]  num_blocks_ff, num_blocks_in;
   logic [LL_W-1:0]  list_length_ff, list_length_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff;
   logic [POS_W-1:0] rsp_position_ff;

   logic             req_acc;
   logic             busy;
   logic             out_blocked;
   logic             finish;
   load_type         load;
   ctl_type          ctl;
   stat_type         stat;
   logic             dp_found;
   logic [POS_W-1:0] dp_position;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      num_blocks_in  = num_blocks_ff;
      list_length_in = list_length_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_BLOCKS:  num_blocks_in  = csr_wdata[NB_W-1:0];
            CSR_LIST_LENGTH: list_length_in = csr_wdata[LL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Decode the request into table writes or a search start
   assign req_ready = !busy;
   assign req_acc   = req_valid && req_ready;

   assign load.idx_we    = req_acc && (req_operation == OP_WRITE_INDEX)
                           && (32'(req_address) < 32'(MAX_BLOCKS));
   assign load.key_we    = req_acc && (req_operation == OP_WRITE_KEY)
                           && (32'(req_address) < 32'(MAX_ITEMS));
   assign load.start     = req_acc && (req_operation == OP_SEARCH);
   assign load.addr      = req_address;
   assign load.key       = req_key_value;
   assign load.blk_start = req_block_start;

   bis_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (load.start),
      .out_blocked (out_blocked),
      .stat        (stat),
      .ctl         (ctl),
      .busy        (busy)
   );

   bis_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .MAX_ITEMS  (MAX_ITEMS)
   ) u_datapath (
      .clock       (clock),
      .load        (load),
      .ctl         (ctl),
      .num_blocks  (num_blocks_ff),
      .list_length (list_length_ff),
      .stat        (stat),
      .found       (dp_found),
      .position    (dp_position)
   );

   // Response register: load on the final step, drop when taken
   assign out_blocked = rsp_valid_ff && !rsp_ready;
   assign finish      = ctl.fire && (ctl.act == ACT_FINISH);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_blocks_ff  <= RST_NUM_BLOCKS;
         list_length_ff <= RST_LIST_LENGTH;
         rsp_valid_ff   <= 1'b0;
      end else begin
         num_blocks_ff  <= num_blocks_in;
         list_length_ff <= list_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_found_ff    <= dp_found;
         rsp_position_ff <= dp_position;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

FILE: rtl/bis_seq.sv
module bis_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               out_blocked,
   input  bis_pkg::stat_type  stat,
   output bis_pkg::ctl_type   ctl,
   output logic               busy
);
   import bis_pkg::*;

   logic      busy_ff, busy_in;
   step_type  pc_ff, pc_in;
   uword_type word;
   logic      take;
   logic      fire;

   // Fetch the control word of the current step
   assign word = ucode_word(pc_ff);

   // Evaluate the jump condition
   always_comb begin
      case (word.cond)
         COND_NEVER:     take = 1'b0;
         COND_ALWAYS:    take = 1'b1;
         COND_LO_GE_HI:  take = stat.lo_ge_hi;
         COND_BLK_NONE:  take = stat.blk_none;
         COND_SCAN_MORE: take = stat.scan_more;
         default:        take = 1'b0;
      endcase
   end

   // Hold the final step while the response register is still occupied
   assign fire = busy_ff && !(word.act == ACT_FINISH && out_blocked);

   // Advance the step counter
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = STEP_INIT;
      end else if (fire) begin
         if (word.act == ACT_FINISH) begin
            busy_in = 1'b0;
         end else if (take) begin
            pc_in = word.target;
         end else begin
            pc_in = step_type'(pc_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= STEP_INIT;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign ctl.fire = fire;
   assign ctl.act  = word.act;
   assign busy     = busy_ff;

endmodule

FILE: rtl/bis_datapath.sv
module bis_datapath #(
   parameter int MAX_BLOCKS = bis_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_ITEMS  = bis_pkg::MAX_ITEMS_DEF
) (
   input  logic                      clock,
   input  bis_pkg::load_type         load,
   input  bis_pkg::ctl_type          ctl,
   input  logic [bis_pkg::NB_W-1:0]  num_blocks,
   input  logic [bis_pkg::LL_W-1:0]  list_length,
   output bis_pkg::stat_type         stat,
   output logic                      found,
   output logic [bis_pkg::POS_W-1:0] position
);
   import bis_pkg::*;

   localparam int BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_BW = $clog2(MAX_BLOCKS + 1);
   localparam int ITM_W  = $clog2(MAX_ITEMS);
   localparam int LEN_W  = $clog2(MAX_ITEMS + 1);
   localparam int EXT_W  = (LEN_W > START_W) ? LEN_W : START_W;

   // Index table and key list
   logic signed [KEY_W-1:0] idx_key_mem   [MAX_BLOCKS];
   logic [START_W-1:0]      idx_start_mem [MAX_BLOCKS];
   logic signed [KEY_W-1:0] list_mem      [MAX_ITEMS];

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] idx_key_rd_ff;
   logic signed [KEY_W-1:0] list_rd_ff;
   logic [START_W-1:0]      st_a_rd_ff;
   logic [START_W-1:0]      st_b_rd_ff;

   logic [CNT_BW-1:0] lo_ff, lo_in;
   logic [CNT_BW-1:0] hi_ff, hi_in;
   logic [CNT_BW-1:0] mid_ff, mid_in;
   logic [START_W-1:0] first_ff, first_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [ITM_W-1:0]  pend_pos_ff, pend_pos_in;
   logic              hit_ff, hit_in;
   logic [ITM_W-1:0]  pos_ff, pos_in;

   logic [CNT_BW-1:0] m_c;
   logic [LEN_W-1:0]  len_c;
   logic [CNT_BW:0]   sum_c;
   logic [CNT_BW:0]   lo_p1_c;
   logic              has_next_c;
   logic [EXT_W-1:0]  end_raw_c;
   logic [EXT_W-1:0]  end_c;
   logic [LEN_W-1:0]  cnt_dec_c;
   logic              more_c;
   logic              scan_hit_c;

   // Saturate the configured sizes to the table depths
   assign m_c   = (32'(num_blocks) > 32'(MAX_BLOCKS)) ? CNT_BW'(MAX_BLOCKS)
                                                      : CNT_BW'(num_blocks);
   assign len_c = (32'(list_length) > 32'(MAX_ITEMS)) ? LEN_W'(MAX_ITEMS)
                                                      : LEN_W'(list_length);

   assign sum_c      = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign lo_p1_c    = {1'b0, lo_ff} + (CNT_BW+1)'(1);
   assign has_next_c = lo_p1_c < {1'b0, m_c};

   // Block end plus one, cut to the list length
   assign end_raw_c = has_next_c ? EXT_W'(st_b_rd_ff) : EXT_W'(len_c);
   assign end_c     = (end_raw_c > EXT_W'(len_c)) ? EXT_W'(len_c) : end_raw_c;

   assign cnt_dec_c  = cnt_ff - LEN_W'(1);
   assign more_c     = EXT_W'(cnt_ff) > EXT_W'(first_ff);
   assign scan_hit_c = pend_ff && (list_rd_ff == key_ff);

   assign stat.lo_ge_hi  = lo_ff >= hi_ff;
   assign stat.blk_none  = (lo_ff >= m_c) || (len_c == '0);
   assign stat.scan_more = !scan_hit_c && more_c;

   // Write loads into the tables
   always_ff @(posedge clock) begin
      if (load.idx_we) begin
         idx_key_mem[BLK_W'(load.addr)]   <= load.key;
         idx_start_mem[BLK_W'(load.addr)] <= load.blk_start;
      end
      if (load.key_we) begin
         list_mem[ITM_W'(load.addr)] <= load.key;
      end
   end

   // Read the index keys during the binary search
   always_ff @(posedge clock) begin
      if (ctl.fire && ctl.act == ACT_BS_ISSUE) begin
         idx_key_rd_ff <= idx_key_mem[mid_in[BLK_W-1:0]];
      end
   end

   // Read this block's start and the next block's start
   always_ff @(posedge clock) begin
      if (ctl.fire && ctl.act == ACT_BLK_ISSUE) begin
         st_a_rd_ff <= idx_start_mem[lo_ff[BLK_W-1:0]];
         st_b_rd_ff <= idx_start_mem[lo_p1_c[BLK_W-1:0]];
      end
   end

   // Read list keys from the block end downward
   always_ff @(posedge clock) begin
      if (ctl.fire && ctl.act == ACT_SCAN && !scan_hit_c && more_c) begin
         list_rd_ff <= list_mem[cnt_dec_c[ITM_W-1:0]];
      end
   end

   // Next values of the search registers
   always_comb begin
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = sum_c[CNT_BW:1];
      first_in    = first_ff;
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      pend_pos_in = pend_pos_ff;
      hit_in      = hit_ff;
      pos_in      = pos_ff;
      if (ctl.fire) begin
         case (ctl.act)
            ACT_INIT: begin
               lo_in   = '0;
               hi_in   = m_c;
               hit_in  = 1'b0;
               pos_in  = '0;
               pend_in = 1'b0;
            end
            ACT_BS_UPDATE: begin
               if (idx_key_rd_ff >= key_ff) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + CNT_BW'(1);
               end
            end
            ACT_BLK_SET: begin
               first_in = st_a_rd_ff;
               cnt_in   = LEN_W'(end_c);
               pend_in  = 1'b0;
            end
            ACT_SCAN: begin
               if (scan_hit_c) begin
                  hit_in = 1'b1;
                  pos_in = pend_pos_ff;
               end else if (more_c) begin
                  cnt_in      = cnt_dec_c;
                  pend_in     = 1'b1;
                  pend_pos_in = cnt_dec_c[ITM_W-1:0];
               end else begin
                  pend_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load.start) begin
         key_ff <= load.key;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      first_ff    <= first_in;
      cnt_ff      <= cnt_in;
      pend_ff     <= pend_in;
      pend_pos_ff <= pend_pos_in;
      hit_ff      <= hit_in;
      pos_ff      <= pos_in;
   end

   assign found    = hit_ff;
   assign position = POS_W'(pos_ff);

endmodule

FILE: rtl/bis_checker.sv
module bis_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [bis_pkg::OP_W-1:0]         req_operation,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_found,
   input logic [bis_pkg::POS_W-1:0]        rsp_position
);
   import bis_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position))
      else $error("stalled response changed");

   // Report position zero on a miss
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with nonzero position");

   // Drop the response right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // Block new requests while a search runs
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_SEARCH |=> !req_ready)
      else $error("request taken during a search");

   // Loads never raise a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation != OP_SEARCH |=> !$rose(rsp_valid))
      else $error("response after a load");

endmodule

bind block_index_search_core bis_checker u_bis_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import bis_pkg::*;

   // Codes with no name in the package
   localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_0 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_1 = 2'd3;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   localparam int SETTLE_CYCLES  = 100;
   localparam int QUIET_LIMIT    = 3000;
   localparam int ERRORS_SHOWN   = 10;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 110;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } answer_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [OP_W-1:0]         req_operation = '0;
   logic [ADDR_W-1:0]       req_address = '0;
   logic signed [KEY_W-1:0] req_key_value = '0;
   logic [START_W-1:0]      req_block_start = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_found;
   logic [POS_W-1:0]        rsp_position;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Mirror of the block's tables and registers
   int                 tbl_max_key [MAX_BLOCKS_DEF];
   logic [START_W-1:0] tbl_block_start [MAX_BLOCKS_DEF];
   int                 tbl_list_key [MAX_ITEMS_DEF];
   logic [NB_W-1:0]    cfg_num_blocks = RST_NUM_BLOCKS;
   logic [LL_W-1:0]    cfg_list_length = RST_LIST_LENGTH;

   answer_type search_answers_due [$];
   int         sort_buf [MAX_ITEMS_DEF];
   int         error_count = 0;
   int         quiet_cycles = 0;
   int         rsp_hold_left = 0;
   bit         idling_on = 1'b1;

   block_index_search_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_address     (req_address),
      .req_key_value   (req_key_value),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, a few long ones, none while idling is off
   function automatic int draw_gap();
      int r;
      if (!idling_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Binary search of the index, then scan the chosen block from its end down
   function automatic answer_type locate_key(input int key);
      answer_type ans;
      int         m, len, lo, hi, mid, first, last, i;
      ans = '0;
      m   = (cfg_num_blocks > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(cfg_num_blocks);
      len = (cfg_list_length > MAX_ITEMS_DEF) ? MAX_ITEMS_DEF : int'(cfg_list_length);
      lo  = 0;
      hi  = m;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (tbl_max_key[mid] >= key)
            hi = mid;
         else
            lo = mid + 1;
      end
      if (lo < m && len > 0) begin
         first = tbl_block_start[lo];
         last  = (lo + 1 < m) ? int'(tbl_block_start[lo + 1]) - 1 : len - 1;
         if (last > len - 1)
            last = len - 1;
         for (i = last; i >= first && !ans.found; i--) begin
            if (tbl_list_key[i] == key) begin
               ans.found    = 1'b1;
               ans.position = i[POS_W-1:0];
            end
         end
      end
      return ans;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= ERRORS_SHOWN)
         $display("%s", msg);
   endtask

   task automatic sort_buf_ascending(input int n);
      int i, j, v;
      for (i = 1; i < n; i++) begin
         v = sort_buf[i];
         j = i - 1;
         while (j >= 0 && sort_buf[j] > v) begin
            sort_buf[j + 1] = sort_buf[j];
            j--;
         end
         sort_buf[j + 1] = v;
      end
   endtask

   // Send one request and update the mirror when it is accepted
   task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input int key, input logic [START_W-1:0] start);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_address     <= addr;
      req_key_value   <= key;
      req_block_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (op)
         OP_WRITE_INDEX: begin
            if (addr < MAX_BLOCKS_DEF) begin
               tbl_max_key[addr]     = key;
               tbl_block_start[addr] = start;
            end
         end
         OP_WRITE_KEY: begin
            if (addr < MAX_ITEMS_DEF)
               tbl_list_key[addr] = key;
         end
         OP_SEARCH: search_answers_due.push_back(locate_key(key));
         default: ;
      endcase
   endtask

   task automatic search_for(input int key);
      send_request(OP_SEARCH, $urandom_range(0, 63), key, $urandom_range(0, 63));
   endtask

   // Hold off until every answer is in and the block has settled
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (search_answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NUM_BLOCKS:  cfg_num_blocks = data[NB_W-1:0];
         CSR_LIST_LENGTH: cfg_list_length = data[LL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] blocks,
                            input logic [CSR_DATA_W-1:0] length);
      drain_responses();
      write_register(CSR_NUM_BLOCKS, blocks);
      write_register(CSR_LIST_LENGTH, length);
   endtask

   // Fill all keys and index entries with a well-ordered random table
   task automatic load_ordered_tables(input int blocks, input int keys);
      int                 i, b, spread, last_pos;
      logic [START_W-1:0] st;
      spread = $urandom_range(0, 2);
      for (i = 0; i < MAX_ITEMS_DEF; i++) begin
         case (spread)
            0:       sort_buf[i] = int'($urandom_range(0, 12)) - 6;
            1:       sort_buf[i] = int'($urandom_range(0, 4000)) - 2000;
            default: sort_buf[i] = $urandom;
         endcase
      end
      sort_buf_ascending(MAX_ITEMS_DEF);
      for (i = 0; i < MAX_ITEMS_DEF; i++)
         send_request(OP_WRITE_KEY, i, sort_buf[i], $urandom_range(0, 63));
      // block starts in ascending order, the first one usually at zero
      for (b = 0; b < MAX_BLOCKS_DEF; b++)
         sort_buf[b] = $urandom_range(0, keys - 1);
      sort_buf_ascending(blocks);
      if ($urandom_range(0, 3) != 0)
         sort_buf[0] = 0;
      for (b = 0; b < MAX_BLOCKS_DEF; b++) begin
         if (b < blocks) begin
            last_pos = (b + 1 < blocks) ? sort_buf[b + 1] - 1 : keys - 1;
            if (last_pos < 0)
               last_pos = 0;
         end else begin
            last_pos = MAX_ITEMS_DEF - 1;
         end
         st = sort_buf[b];
         send_request(OP_WRITE_INDEX, b, tbl_list_key[last_pos], st);
      end
   endtask

   // Fixed pattern of four-key blocks, then search with the reset settings
   task automatic test_reset_defaults();
      int                 i, b, key;
      logic [START_W-1:0] st;
      for (i = 0; i < MAX_ITEMS_DEF; i++) begin
         if (i == 0)
            key = KEY_MIN;
         else if (i == MAX_ITEMS_DEF - 1)
            key = KEY_MAX;
         else if (i == 21)
            key = (20 - 32) * 1000;
         else
            key = (i - 32) * 1000;
         send_request(OP_WRITE_KEY, i, key, $urandom_range(0, 63));
      end
      for (b = 0; b < MAX_BLOCKS_DEF; b++) begin
         st = b * 4;
         send_request(OP_WRITE_INDEX, b, tbl_list_key[b * 4 + 3], st);
      end
      // one block spans the whole list
      search_for(tbl_list_key[2]);
      search_for(tbl_list_key[50]);
   endtask

   task automatic test_directed_cases();
      configure(MAX_BLOCKS_DEF, MAX_ITEMS_DEF);
      search_for(KEY_MIN);
      search_for(KEY_MAX);
      // duplicate key: the higher position wins
      search_for(tbl_list_key[20]);
      search_for(tbl_list_key[36]);
      search_for(tbl_list_key[39]);
      search_for(tbl_list_key[10] + 1);
      // unused code and an index write past the table: no answer
      send_request(OP_UNUSED, '1, -1, '1);
      send_request(OP_WRITE_INDEX, '1, $urandom, '1);
      search_for(tbl_list_key[60]);
      // empty block: start moved past the next block's start, then restored
      send_request(OP_WRITE_INDEX, 9, tbl_list_key[39], 44);
      search_for(tbl_list_key[37]);
      send_request(OP_WRITE_INDEX, 9, tbl_list_key[39], 36);
      search_for(tbl_list_key[37]);
   endtask

   task automatic test_config_extremes();
      // no blocks in use
      configure(0, MAX_ITEMS_DEF);
      search_for(tbl_list_key[5]);
      // both registers past their limits saturate
      configure('1, '1);
      search_for(tbl_list_key[62]);
      search_for(KEY_MAX);
      // single key list
      configure(1, 1);
      search_for(tbl_list_key[0]);
      search_for(tbl_list_key[1]);
      // empty list
      configure(MAX_BLOCKS_DEF, 0);
      search_for(tbl_list_key[0]);
      // block end cut at the list length
      configure(MAX_BLOCKS_DEF, 10);
      search_for(tbl_list_key[9]);
      search_for(tbl_list_key[10]);
      // last block runs to the list end; key above every maximum
      configure(3, MAX_ITEMS_DEF);
      search_for(tbl_list_key[50]);
      search_for(tbl_list_key[12]);
      // spare register indexes change nothing
      drain_responses();
      write_register(CSR_SPARE_0, $urandom);
      write_register(CSR_SPARE_1, $urandom);
      search_for(tbl_list_key[30]);
   endtask

   task automatic test_random_traffic();
      int phase, n, r, nb, len, m_eff, len_eff, key, top;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         r = $urandom_range(0, 99);
         if (r < 10)
            nb = 0;
         else if (r < 20)
            nb = $urandom_range(MAX_BLOCKS_DEF + 1, 31);
         else if (r < 35)
            nb = MAX_BLOCKS_DEF;
         else
            nb = $urandom_range(1, MAX_BLOCKS_DEF);
         r = $urandom_range(0, 99);
         if (r < 8)
            len = 0;
         else if (r < 16)
            len = $urandom_range(MAX_ITEMS_DEF + 1, 127);
         else if (r < 30)
            len = MAX_ITEMS_DEF;
         else
            len = $urandom_range(1, MAX_ITEMS_DEF);
         configure(nb, len);
         // one phase runs with no idling on either side
         idling_on = (phase != 3);
         m_eff   = (nb > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : nb;
         len_eff = (len > MAX_ITEMS_DEF) ? MAX_ITEMS_DEF : len;
         load_ordered_tables((m_eff == 0) ? 1 : m_eff, (len_eff == 0) ? 1 : len_eff);
         top = (m_eff == 0) ? 0 : m_eff - 1;
         for (n = 0; n < PHASE_REQUESTS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
               r = $urandom_range(0, 99);
               if (r < 45)
                  key = tbl_list_key[$urandom_range(0, 63)];
               else if (r < 60)
                  key = tbl_max_key[$urandom_range(0, 15)];
               else if (r < 70)
                  key = tbl_list_key[$urandom_range(0, 63)] + ($urandom_range(0, 1) ? 1 : -1);
               else if (r < 80)
                  key = $urandom;
               else if (r < 88)
                  key = tbl_max_key[top] + 1;
               else if (r < 94)
                  key = KEY_MAX;
               else
                  key = KEY_MIN;
               search_for(key);
            end else begin
               // noise: unused code, ignored or disordering loads
               case ($urandom_range(0, 3))
                  0: send_request(OP_UNUSED, $urandom_range(0, 63), $urandom,
                                  $urandom_range(0, 63));
                  1: send_request(OP_WRITE_INDEX, $urandom_range(MAX_BLOCKS_DEF, 63),
                                  $urandom, $urandom_range(0, 63));
                  2: send_request(OP_WRITE_INDEX, $urandom_range(0, MAX_BLOCKS_DEF - 1),
                                  $urandom, $urandom_range(0, 63));
                  default: send_request(OP_WRITE_KEY, $urandom_range(0, 63), $urandom,
                                        $urandom_range(0, 63));
               endcase
            end
         end
      end
      idling_on = 1'b1;
   endtask

   // Stall the response side now and then
   always @(posedge clock) begin : drive_rsp_ready
      int gap;
      if (rsp_hold_left > 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? draw_gap() : 0;
         rsp_ready     <= (gap == 0);
         rsp_hold_left <= (gap > 0) ? gap - 1 : 0;
      end
   end

   // Compare each accepted answer with the oldest one due
   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (search_answers_due.size() == 0) begin
            report_error($sformatf("unexpected answer: found=%0d position=%0d",
                                   rsp_found, rsp_position));
         end else begin
            want = search_answers_due.pop_front();
            if (rsp_found !== want.found || rsp_position !== want.position)
               report_error($sformatf(
                  "answer mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                  want.found, want.position, rsp_found, rsp_position));
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** block_index_search_core: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_cases();
      test_config_extremes();
      test_random_traffic();
      drain_responses();
      if (error_count == 0)
         $display("** block_index_search_core: PASSED **");
      else
         $display("** block_index_search_core: FAILED **");
      $finish;
   end

endmodule

FILE: block_index_search_core.f
rtl/bis_pkg.sv
rtl/bis_seq.sv
rtl/bis_datapath.sv
rtl/block_index_search_core.sv
rtl/bis_checker.sv
tb/testbench.sv
